/* rtl/mpr_pkg.sv */
// Shared types and constants for the multi-pattern find-and-replace block.
`default_nettype none
package mpr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SLOT_W    = 59;
  localparam int unsigned LEN_LSB   = 56;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned MAX_SLOTS = 4;
  localparam int unsigned SLOT_IDX_W = 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned CMD_FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SEARCH0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE0 = 3'd4;

  typedef logic [SLOT_W-1:0] slot_reg_t;

  typedef struct packed {
    logic                  is_copy;
    logic [BYTE_W-1:0]     data;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  run_last;
    logic                  stream_end;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/mpr_cfg.sv */
// Register file holding the search patterns and their replacements.
`default_nettype none
module mpr_cfg
  import mpr_pkg::*;
#(
  parameter int unsigned PATTERN_SLOTS = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SLOT_W-1:0]    cfg_data_i,
  output slot_reg_t                 search_o  [PATTERN_SLOTS],
  output slot_reg_t                 replace_o [PATTERN_SLOTS]
);

  slot_reg_t search_q  [PATTERN_SLOTS];
  slot_reg_t replace_q [PATTERN_SLOTS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        search_q[s]  <= '0;
        replace_q[s] <= '0;
      end
    end else if (cfg_valid_i) begin
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        if (cfg_index_i == REG_SEARCH0 + CFG_IDX_W'(s)) begin
          search_q[s] <= cfg_data_i;
        end
        if (cfg_index_i == REG_REPLACE0 + CFG_IDX_W'(s)) begin
          replace_q[s] <= cfg_data_i;
        end
      end
    end
  end

  assign search_o  = search_q;
  assign replace_o = replace_q;

endmodule
`default_nettype wire

/* rtl/mpr_cmd_fifo.sv */
// Short command queue between the window front end and the output back end.
`default_nettype none
module mpr_cmd_fifo
  import mpr_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("Command queue written while full.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("Command queue read while empty.");

endmodule
`default_nettype wire

/* rtl/mpr_front.sv */
// Lookahead window that matches patterns at its head and issues output commands.
`default_nettype none
module mpr_front
  import mpr_pkg::*;
#(
  parameter int unsigned PATTERN_SLOTS     = 4,
  parameter int unsigned MAX_PATTERN_BYTES = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [BYTE_W-1:0] in_byte_i,
  input  wire logic              in_last_i,
  input  wire slot_reg_t         search_i  [PATTERN_SLOTS],
  input  wire slot_reg_t         replace_i [PATTERN_SLOTS],
  input  wire logic              fifo_full_i,
  output logic                   push_o,
  output cmd_t                   push_cmd_o
);

  localparam int unsigned WIN_W  = MAX_PATTERN_BYTES * BYTE_W;
  localparam int unsigned FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

  logic [WIN_W-1:0]  win_q, win_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              flush_q, flush_d;
  logic              pend_valid_q, pend_valid_d;
  cmd_t              pend_q, pend_d;

  logic              in_acc;
  logic [WIN_W-1:0]  view_win;
  logic [LEN_W-1:0]  view_fill;
  logic              found;
  logic [LEN_W-1:0]  best_len;
  logic [SLOT_IDX_W-1:0] best_slot;
  logic [PATTERN_SLOTS-1:0] slot_hit;
  logic              emits;
  logic [LEN_W-1:0]  drop;
  logic [LEN_W-1:0]  rest_fill;
  logic [WIN_W-1:0]  shifted;
  cmd_t              new_cmd;

  assign in_stall_o = flush_q | fifo_full_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign view_win  = flush_q ? win_q
                             : (win_q | (WIN_W'(in_byte_i) << {fill_q, 3'b000}));
  assign view_fill = flush_q ? LEN_W'(fill_q) : LEN_W'(fill_q) + LEN_W'(1);

  always_comb begin
    logic [LEN_W-1:0] len;
    for (int s = 0; s < PATTERN_SLOTS; s++) begin
      len = search_i[s][LEN_LSB +: LEN_W];
      slot_hit[s] = (len != '0) && (len <= LEN_W'(MAX_PATTERN_BYTES)) && (len <= view_fill);
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        if ((LEN_W'(k) < len) &&
            (view_win[k*BYTE_W +: BYTE_W] != search_i[s][k*BYTE_W +: BYTE_W])) begin
          slot_hit[s] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    found     = 1'b0;
    best_len  = '0;
    best_slot = '0;
    for (int s = 0; s < PATTERN_SLOTS; s++) begin
      if (slot_hit[s] && (!found || (search_i[s][LEN_LSB +: LEN_W] < best_len))) begin
        found     = 1'b1;
        best_len  = search_i[s][LEN_LSB +: LEN_W];
        best_slot = SLOT_IDX_W'(s);
      end
    end
  end

  always_comb begin
    emits = 1'b1;
    if (found) begin
      for (int s = 0; s < PATTERN_SLOTS; s++) begin
        if (best_slot == SLOT_IDX_W'(s)) begin
          emits = (replace_i[s][LEN_LSB +: LEN_W] != '0);
        end
      end
    end
  end

  assign drop      = found ? best_len : LEN_W'(1);
  assign rest_fill = view_fill - drop;
  assign shifted   = view_win >> {drop, 3'b000};

  assign new_cmd.is_copy    = ~found;
  assign new_cmd.data       = view_win[BYTE_W-1:0];
  assign new_cmd.slot       = best_slot;
  assign new_cmd.run_last   = ~flush_q;
  assign new_cmd.stream_end = 1'b0;

  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    flush_d      = flush_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    push_o       = 1'b0;
    push_cmd_o   = new_cmd;
    if (!flush_q) begin
      if (in_acc) begin
        if (in_last_i) begin
          win_d   = view_win;
          fill_d  = view_fill[FILL_W-1:0];
          flush_d = 1'b1;
        end else if (view_fill == LEN_W'(MAX_PATTERN_BYTES)) begin
          win_d  = shifted;
          fill_d = rest_fill[FILL_W-1:0];
          push_o = emits;
        end else begin
          win_d  = view_win;
          fill_d = view_fill[FILL_W-1:0];
        end
      end
    end else if (!fifo_full_i) begin
      if (fill_q != '0) begin
        win_d  = shifted;
        fill_d = rest_fill[FILL_W-1:0];
        if (emits) begin
          pend_d       = new_cmd;
          pend_valid_d = 1'b1;
          push_o       = pend_valid_q;
          push_cmd_o   = pend_q;
        end
      end else begin
        push_o                = pend_valid_q;
        push_cmd_o            = pend_q;
        push_cmd_o.run_last   = 1'b1;
        push_cmd_o.stream_end = 1'b1;
        pend_valid_d          = 1'b0;
        flush_d               = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= '0;
      fill_q       <= '0;
      flush_q      <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      win_q        <= win_d;
      fill_q       <= fill_d;
      flush_q      <= flush_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  a_fill_below_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flush_q |-> (fill_q < FILL_W'(MAX_PATTERN_BYTES)))
    else $error("Window full outside of a flush.");

  a_pend_only_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> flush_q) else $error("Held command outside of a flush.");

endmodule
`default_nettype wire

/* rtl/mpr_back.sv */
// Expands queued commands into output bytes and drives the output register.
`default_nettype none
module mpr_back
  import mpr_pkg::*;
#(
  parameter int unsigned PATTERN_SLOTS = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cmd_t         head_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  input  wire slot_reg_t    replace_i [PATTERN_SLOTS],
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              run_last_o,
  output logic              stream_end_o
);

  logic [LEN_W-1:0]  idx_q, idx_d;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              run_last_q;
  logic              stream_end_q;

  slot_reg_t         rep_sel;
  logic [LEN_W-1:0]  rep_len;
  logic              emit;
  logic              done;
  logic [BYTE_W-1:0] emit_byte;

  always_comb begin
    rep_sel = '0;
    for (int s = 0; s < PATTERN_SLOTS; s++) begin
      if (head_i.slot == SLOT_IDX_W'(s)) begin
        rep_sel = replace_i[s];
      end
    end
  end

  assign rep_len   = rep_sel[LEN_LSB +: LEN_W];
  assign emit      = !empty_i && (!out_valid_q || !out_stall_i);
  assign done      = head_i.is_copy || (idx_q == rep_len - LEN_W'(1));
  assign emit_byte = head_i.is_copy ? head_i.data : rep_sel[{idx_q, 3'b000} +: BYTE_W];
  assign pop_o     = emit && done;

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (emit) begin
      idx_d = idx_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q   <= emit_byte;
      run_last_q   <= head_i.run_last & done;
      stream_end_q <= head_i.stream_end & done;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign stream_end_o = stream_end_q;

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stream_end_q) |-> run_last_q)
    else $error("Stream end flagged on a byte that does not close its run.");

endmodule
`default_nettype wire

/* rtl/multi_pattern_replace_top.sv */
// Top level of the streaming multi-pattern find-and-replace block.
// Throughput: one input byte per cycle while the window slides and the command queue is not full;
// a replacement of r bytes expands from one command held in a four-entry command queue.
// A resolved window head passes through the command queue into the output register.
// A final byte is followed by a flush that resolves the remaining window heads, with no input taken.
// Reset clears the window, the queue, the output valid flag and all pattern registers.
`default_nettype none
module multi_pattern_replace_top
  import mpr_pkg::*;
#(
  parameter int unsigned PATTERN_SLOTS     = 4,
  parameter int unsigned MAX_PATTERN_BYTES = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [BYTE_W-1:0]    in_byte_i,
  input  wire logic                 in_last_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [BYTE_W-1:0]         out_byte_o,
  output logic                      run_last_o,
  output logic                      stream_end_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SLOT_W-1:0]    cfg_data_i
);

  slot_reg_t search  [PATTERN_SLOTS];
  slot_reg_t replace [PATTERN_SLOTS];
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;
  logic      fifo_empty;
  logic      fifo_full;

  mpr_cfg #(
    .PATTERN_SLOTS(PATTERN_SLOTS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .search_o   (search),
    .replace_o  (replace)
  );

  mpr_front #(
    .PATTERN_SLOTS    (PATTERN_SLOTS),
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .search_i   (search),
    .replace_i  (replace),
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  mpr_cmd_fifo #(
    .DEPTH(CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (fifo_empty),
    .full_o    (fifo_full)
  );

  mpr_back #(
    .PATTERN_SLOTS(PATTERN_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .replace_i   (replace),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .stream_end_o(stream_end_o)
  );

endmodule
`default_nettype wire
